// ===== rtl/ksct_pkg.sv =====
// ----------------------------------------------------------------------------
// ksct_pkg
// Shared types and constants for the k-mer sort-and-count table.
// ----------------------------------------------------------------------------
package ksct_pkg;

    localparam int CAPACITY = 4096;
    localparam int AW       = $clog2(CAPACITY);   // memory address bits
    localparam int CW       = AW + 1;             // fill counts, run counts
    localparam int PW       = AW + 2;             // merge bounds, base + 2 * width
    localparam int KW       = 128;                // {high, low} key
    localparam int IW       = 12;                 // index field
    localparam int STW      = 2;

    localparam logic [2:0] OPC_INSERT = 3'd0;
    localparam logic [2:0] OPC_BUILD  = 3'd1;
    localparam logic [2:0] OPC_QUERY  = 3'd2;
    localparam logic [2:0] OPC_CLEAR  = 3'd3;
    localparam logic [2:0] OPC_READ   = 3'd4;

    localparam logic [STW-1:0] STAT_OK    = 2'd0;
    localparam logic [STW-1:0] STAT_FULL  = 2'd1;
    localparam logic [STW-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_BUILD,
        OP_QUERY,
        OP_CLEAR,
        OP_READ,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t           op;
        logic [KW-1:0] key;
        logic [IW-1:0] index;
    } q_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_Q_RD,
        ST_Q_CMP,
        ST_M_SETUP,
        ST_M_RD,
        ST_M_CMP,
        ST_C_RD,
        ST_C_CMP,
        ST_C_END
    } state_t;

    function automatic op_t decode_op(input logic [2:0] code);
        op_t r;
        case (code)
            OPC_INSERT: r = OP_INSERT;
            OPC_BUILD:  r = OP_BUILD;
            OPC_QUERY:  r = OP_QUERY;
            OPC_CLEAR:  r = OP_CLEAR;
            OPC_READ:   r = OP_READ;
            default:    r = OP_NONE;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ksct_front.sv =====
// ----------------------------------------------------------------------------
// ksct_front
// Accepts input items, decodes the operation and queues them (two deep).
// ----------------------------------------------------------------------------
module ksct_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [143:0]       s_tdata,
    input  logic [2:0]         s_tuser,
    output logic               q_valid,
    output ksct_pkg::q_item_t  q_item,
    input  logic               q_pop
);

    ksct_pkg::q_item_t fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    ksct_pkg::q_item_t in_item;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb begin
        in_item.op    = ksct_pkg::decode_op(s_tuser);
        in_item.key   = {s_tdata[63:0], s_tdata[127:64]};
        in_item.index = s_tdata[139:128];
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next      = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/ksct_back.sv =====
// ----------------------------------------------------------------------------
// ksct_back
// Executes queued operations: raw buffer, merge sort, run collapse, table
// lookup, and the result register.
// ----------------------------------------------------------------------------
module ksct_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  ksct_pkg::q_item_t  q_item,
    output logic               q_pop,
    input  logic [12:0]        min_cov,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [159:0]       m_tdata,
    output logic [1:0]         m_tuser
);

    localparam int AW = ksct_pkg::AW;
    localparam int CW = ksct_pkg::CW;
    localparam int PW = ksct_pkg::PW;
    localparam int KW = ksct_pkg::KW;

    // memories
    logic [KW-1:0] bank_a [ksct_pkg::CAPACITY];
    logic [KW-1:0] bank_b [ksct_pkg::CAPACITY];
    logic [KW-1:0] tab_key [ksct_pkg::CAPACITY];
    logic [CW-1:0] tab_cnt [ksct_pkg::CAPACITY];

    logic [AW-1:0] rd0_addr, rd1_addr, t_addr;
    logic [KW-1:0] a0_q, a1_q, b0_q, b1_q, tk_q;
    logic [CW-1:0] tc_q;
    logic          we_a, we_b, we_t;
    logic [AW-1:0] wa_addr, wb_addr, wt_addr;
    logic [KW-1:0] wa_data, wb_data, wt_key;
    logic [CW-1:0] wt_cnt;

    ksct_pkg::state_t state_reg, state_next;
    logic [CW-1:0] raw_fill_reg, raw_fill_next;
    logic [CW-1:0] tab_fill_reg, tab_fill_next;
    logic [CW-1:0] n_reg, n_next;
    logic [PW-1:0] w_reg, w_next;
    logic [PW-1:0] base_reg, base_next;
    logic [PW-1:0] i_reg, i_next, iend_reg, iend_next;
    logic [PW-1:0] j_reg, j_next, jend_reg, jend_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_reg, src_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] run_reg, run_next;
    logic [KW-1:0] cur_reg, cur_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [KW-1:0] qkey_reg, qkey_next;

    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;
    logic [KW-1:0] out_key_reg, out_key_next;
    logic [CW-1:0] out_ent_reg, out_ent_next;
    logic [1:0]    out_st_reg, out_st_next;

    logic [KW-1:0] left_d, right_d, seq_d;
    logic [PW-1:0] sum_w, sum_2w;
    logic [CW-1:0] mid_c;
    logic          take_left;

    assign left_d  = src_reg ? b0_q : a0_q;
    assign right_d = src_reg ? b1_q : a1_q;
    assign seq_d   = left_d;
    assign sum_w   = base_reg + w_reg;
    assign sum_2w  = base_reg + {w_reg[PW-2:0], 1'b0};
    assign mid_c   = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_st_reg;
    assign m_tdata  = {6'd0, out_ent_reg, out_key_reg[63:0], out_key_reg[127:64], out_cnt_reg};

    always_comb begin
        state_next     = state_reg;
        raw_fill_next  = raw_fill_reg;
        tab_fill_next  = tab_fill_reg;
        n_next         = n_reg;
        w_next         = w_reg;
        base_next      = base_reg;
        i_next         = i_reg;
        iend_next      = iend_reg;
        j_next         = j_reg;
        jend_next      = jend_reg;
        k_next         = k_reg;
        src_next       = src_reg;
        p_next         = p_reg;
        run_next       = run_reg;
        cur_next       = cur_reg;
        kept_next      = kept_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        qkey_next      = qkey_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cnt_next   = out_cnt_reg;
        out_key_next   = out_key_reg;
        out_ent_next   = out_ent_reg;
        out_st_next    = out_st_reg;
        q_pop          = 1'b0;
        rd0_addr       = i_reg[AW-1:0];
        rd1_addr       = j_reg[AW-1:0];
        t_addr         = mid_reg;
        we_a           = 1'b0;
        we_b           = 1'b0;
        we_t           = 1'b0;
        wa_addr        = k_reg[AW-1:0];
        wb_addr        = k_reg[AW-1:0];
        wt_addr        = kept_reg[AW-1:0];
        wa_data        = left_d;
        wb_data        = left_d;
        wt_key         = cur_reg;
        wt_cnt         = run_reg;
        take_left      = 1'b0;

        case (state_reg)
            ksct_pkg::ST_IDLE: begin
                if (q_valid && !out_valid_reg) begin
                    q_pop        = 1'b1;
                    out_cnt_next = '0;
                    out_key_next = '0;
                    out_st_next  = ksct_pkg::STAT_OK;
                    out_ent_next = tab_fill_reg;
                    case (q_item.op)
                        ksct_pkg::OP_INSERT: begin
                            out_valid_next = 1'b1;
                            if (raw_fill_reg < CW'(ksct_pkg::CAPACITY)) begin
                                we_a          = 1'b1;
                                wa_addr       = raw_fill_reg[AW-1:0];
                                wa_data       = q_item.key;
                                raw_fill_next = raw_fill_reg + 1'b1;
                            end else begin
                                out_st_next = ksct_pkg::STAT_FULL;
                            end
                        end
                        ksct_pkg::OP_BUILD: begin
                            n_next    = raw_fill_reg;
                            src_next  = 1'b0;
                            w_next    = PW'(1);
                            base_next = '0;
                            k_next    = '0;
                            p_next    = '0;
                            run_next  = '0;
                            kept_next = '0;
                            state_next = (raw_fill_reg < CW'(2)) ? ksct_pkg::ST_C_RD
                                                                 : ksct_pkg::ST_M_SETUP;
                        end
                        ksct_pkg::OP_QUERY: begin
                            qkey_next  = q_item.key;
                            lo_next    = '0;
                            hi_next    = tab_fill_reg;
                            state_next = ksct_pkg::ST_Q_RD;
                        end
                        ksct_pkg::OP_CLEAR: begin
                            tab_fill_next  = '0;
                            out_ent_next   = '0;
                            out_valid_next = 1'b1;
                        end
                        ksct_pkg::OP_READ: begin
                            if ({1'b0, q_item.index} < tab_fill_reg) begin
                                t_addr     = q_item.index[AW-1:0];
                                state_next = ksct_pkg::ST_RD_WAIT;
                            end else begin
                                out_st_next    = ksct_pkg::STAT_RANGE;
                                out_valid_next = 1'b1;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ksct_pkg::ST_RD_WAIT: begin
                out_cnt_next   = tc_q;
                out_key_next   = tk_q;
                out_valid_next = 1'b1;
                state_next     = ksct_pkg::ST_IDLE;
            end
            ksct_pkg::ST_Q_RD: begin
                if (lo_reg >= hi_reg) begin
                    out_valid_next = 1'b1;
                    state_next     = ksct_pkg::ST_IDLE;
                end else begin
                    mid_next   = mid_c[AW-1:0];
                    t_addr     = mid_c[AW-1:0];
                    state_next = ksct_pkg::ST_Q_CMP;
                end
            end
            ksct_pkg::ST_Q_CMP: begin
                if (tk_q == qkey_reg) begin
                    out_cnt_next   = tc_q;
                    out_key_next   = qkey_reg;
                    out_valid_next = 1'b1;
                    state_next     = ksct_pkg::ST_IDLE;
                end else begin
                    if (tk_q < qkey_reg) begin
                        lo_next = {1'b0, mid_reg} + 1'b1;
                    end else begin
                        hi_next = {1'b0, mid_reg};
                    end
                    state_next = ksct_pkg::ST_Q_RD;
                end
            end
            ksct_pkg::ST_M_SETUP: begin
                i_next     = base_reg;
                j_next     = (sum_w < PW'(n_reg)) ? sum_w : PW'(n_reg);
                iend_next  = (sum_w < PW'(n_reg)) ? sum_w : PW'(n_reg);
                jend_next  = (sum_2w < PW'(n_reg)) ? sum_2w : PW'(n_reg);
                state_next = ksct_pkg::ST_M_RD;
            end
            ksct_pkg::ST_M_RD: begin
                if (i_reg == iend_reg && j_reg == jend_reg) begin
                    // this pair of runs is merged; step to the next pair or pass
                    if (sum_2w >= PW'(n_reg)) begin
                        src_next  = ~src_reg;
                        w_next    = {w_reg[PW-2:0], 1'b0};
                        base_next = '0;
                        k_next    = '0;
                        state_next = ({w_reg[PW-2:0], 1'b0} >= PW'(n_reg))
                                     ? ksct_pkg::ST_C_RD : ksct_pkg::ST_M_SETUP;
                    end else begin
                        base_next  = sum_2w;
                        state_next = ksct_pkg::ST_M_SETUP;
                    end
                end else begin
                    state_next = ksct_pkg::ST_M_CMP;
                end
            end
            ksct_pkg::ST_M_CMP: begin
                take_left = (i_reg < iend_reg) &&
                            ((j_reg >= jend_reg) || !(right_d < left_d));
                if (src_reg) begin
                    we_a    = 1'b1;
                    wa_data = take_left ? left_d : right_d;
                end else begin
                    we_b    = 1'b1;
                    wb_data = take_left ? left_d : right_d;
                end
                k_next = k_reg + 1'b1;
                if (take_left) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    j_next = j_reg + 1'b1;
                end
                state_next = ksct_pkg::ST_M_RD;
            end
            ksct_pkg::ST_C_RD: begin
                rd0_addr = p_reg[AW-1:0];
                state_next = (p_reg == n_reg) ? ksct_pkg::ST_C_END : ksct_pkg::ST_C_CMP;
            end
            ksct_pkg::ST_C_CMP: begin
                if (p_reg == '0 || seq_d != cur_reg) begin
                    // close the previous run, keep it if it is covered enough
                    if (p_reg != '0 && run_reg >= min_cov) begin
                        we_t      = 1'b1;
                        kept_next = kept_reg + 1'b1;
                    end
                    cur_next = seq_d;
                    run_next = CW'(1);
                end else begin
                    run_next = run_reg + 1'b1;
                end
                p_next     = p_reg + 1'b1;
                state_next = ksct_pkg::ST_C_RD;
            end
            ksct_pkg::ST_C_END: begin
                if (n_reg != '0 && run_reg >= min_cov) begin
                    we_t          = 1'b1;
                    tab_fill_next = kept_reg + 1'b1;
                end else begin
                    tab_fill_next = kept_reg;
                end
                raw_fill_next  = '0;
                out_ent_next   = tab_fill_next;
                out_valid_next = 1'b1;
                state_next     = ksct_pkg::ST_IDLE;
            end
            default: begin
                state_next = ksct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ksct_pkg::ST_IDLE;
            raw_fill_reg  <= '0;
            tab_fill_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            raw_fill_reg  <= raw_fill_next;
            tab_fill_reg  <= tab_fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        w_reg       <= w_next;
        base_reg    <= base_next;
        i_reg       <= i_next;
        iend_reg    <= iend_next;
        j_reg       <= j_next;
        jend_reg    <= jend_next;
        k_reg       <= k_next;
        src_reg     <= src_next;
        p_reg       <= p_next;
        run_reg     <= run_next;
        cur_reg     <= cur_next;
        kept_reg    <= kept_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        qkey_reg    <= qkey_next;
        out_cnt_reg <= out_cnt_next;
        out_key_reg <= out_key_next;
        out_ent_reg <= out_ent_next;
        out_st_reg  <= out_st_next;
    end

    always_ff @(posedge aclk) begin
        if (we_a) begin
            bank_a[wa_addr] <= wa_data;
        end
        a0_q <= bank_a[rd0_addr];
        a1_q <= bank_a[rd1_addr];
    end

    always_ff @(posedge aclk) begin
        if (we_b) begin
            bank_b[wb_addr] <= wb_data;
        end
        b0_q <= bank_b[rd0_addr];
        b1_q <= bank_b[rd1_addr];
    end

    always_ff @(posedge aclk) begin
        if (we_t) begin
            tab_key[wt_addr] <= wt_key;
            tab_cnt[wt_addr] <= wt_cnt;
        end
        tk_q <= tab_key[t_addr];
        tc_q <= tab_cnt[t_addr];
    end

endmodule

// ===== rtl/kmer_sort_count_table.sv =====
// ----------------------------------------------------------------------------
// kmer_sort_count_table
// Counting table for 128-bit k-mers: insert, build (sort and collapse),
// query by binary search, read by index, clear.
// ----------------------------------------------------------------------------
// Insert, clear, unknown ops, out-of-range read: result registered when popped.
// Read: via ST_RD_WAIT. Query: binary search, a read then a compare state per probe.
// Build: merge sort passes, a setup per pair of runs and a compare per element, then a
// collapse walk that reads each element once and keeps runs of at least min_coverage.
// One item at a time: the next item starts once the previous result has been taken.
// Synchronous active-low reset empties buffer and table and sets min_coverage to 2.
module kmer_sort_count_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // kmer_high, kmer_low, index, zero pad
    input  logic [2:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // count, found_high, found_low, entries, zero pad
    output logic [1:0]   m_tuser,   // status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [12:0]  cfg_data   // min_coverage
);

    logic              q_valid;
    logic              q_pop;
    ksct_pkg::q_item_t q_item;
    logic [12:0]       min_cov_reg, min_cov_next;

    assign cfg_ready    = 1'b1;
    assign min_cov_next = (cfg_valid && cfg_ready) ? cfg_data : min_cov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_cov_reg <= 13'd2;
        end else begin
            min_cov_reg <= min_cov_next;
        end
    end

    ksct_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ksct_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .min_cov  (min_cov_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
